@@ src/klss_pkg.sv @@
// Package: shared types and constants for the k-th order statistic selector.
package klss_pkg;

    localparam int ValueW  = 64;
    localparam int RankW   = 16;
    localparam int StatusW = 2;

    typedef enum logic [0:0] {
        REQ_PUSH  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OUTER_RD,
        S_OUTER_WAIT,
        S_INNER,
        S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [0:0]         req_type;
        logic [ValueW-1:0]  value;
        logic signed [RankW-1:0] rank;
        logic [0:0]         descending;
    } t_in_item;

    typedef struct packed {
        logic [ValueW-1:0]  selected;
        logic [StatusW-1:0] status;
    } t_out_item;

    // Map a double bit pattern to an unsigned key that orders like the value.
    function automatic logic [ValueW-1:0] order_key(input logic [ValueW-1:0] bits);
        logic [ValueW-1:0] k;
        begin
            if (bits[ValueW-1]) begin
                k = ~bits;
            end else begin
                k = bits | {1'b1, {(ValueW-1){1'b0}}};
            end
            return k;
        end
    endfunction

endpackage

@@ src/klss_if.sv @@
// Interfaces: valid/ready channels for input and result items.
interface klss_in_if import klss_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface klss_out_if import klss_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/kth_largest_smallest_select_top.sv @@
// Top level: k-th largest/smallest selection over a stored set of doubles.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    req_type, value, rank, descending
//   out_ch    out   valid/ready    selected, status
//
// A query with a valid rank walks candidate i over the stored set and, for
// each, streams all N entries through the second read port, ending early
// when the candidate is found. Error queries go straight to the output state.
// Reset clears count, overflow and control.
// The result waits in an output register; input is held off until taken.
module kth_largest_smallest_select_top import klss_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    klss_in_if.sink    i_in,
    klss_out_if.source o_out
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_less, n_less;
    logic [CW-1:0] r_equal, n_equal;
    logic          r_jv, n_jv;
    logic [ValueW-1:0] r_cand, n_cand;
    t_out_item     r_out, n_out;
    logic          r_ovalid, n_ovalid;

    logic              we;
    logic [AW-1:0]     waddr, raddr_a, raddr_b;
    logic [ValueW-1:0] rdata_a, rdata_b;
    logic              acc;
    logic [CW-1:0]     rank_c;
    logic [ValueW-1:0] key_c, key_b;
    logic [CW:0]       le_sum;

    klss_ram #(.WIDTH(ValueW), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_in.data.value),
        .i_raddr(raddr_a), .o_rdata(rdata_a));
    klss_ram #(.WIDTH(ValueW), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_in.data.value),
        .i_raddr(raddr_b), .o_rdata(rdata_b));

    assign acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign we      = acc && (i_in.data.req_type == REQ_PUSH) && (r_count < CW'(DEPTH));
    assign waddr   = r_count[AW-1:0];
    assign raddr_a = r_i[AW-1:0];
    assign raddr_b = r_j[AW-1:0];
    assign rank_c  = i_in.data.rank[CW-1:0];
    assign key_c   = order_key(r_cand);
    assign key_b   = order_key(rdata_b);
    assign le_sum  = {1'b0, r_less} + {1'b0, r_equal};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_in.data.req_type == REQ_QUERY) begin
                    if (r_ovf || r_count == '0
                        || i_in.data.rank < 1
                        || $signed({1'b0, i_in.data.rank}) > $signed({1'b0, r_count})) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_OUTER_RD;
                    end
                end
            end
            S_OUTER_RD:   n_state = S_OUTER_WAIT;
            S_OUTER_WAIT: n_state = S_INNER;
            S_INNER:      if (!r_jv && r_j == r_count) n_state = S_DONE;
            S_DONE: begin
                if ({1'b0, r_less} < {1'b0, r_pos} && {1'b0, r_pos} <= le_sum) n_state = S_OUT;
                else if (r_i + CW'(1) == r_count) n_state = S_OUT;
                else n_state = S_OUTER_RD;
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_pos    = r_pos;
        n_i      = r_i;
        n_j      = r_j;
        n_less   = r_less;
        n_equal  = r_equal;
        n_jv     = 1'b0;
        n_cand   = r_cand;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        if (o_out.valid && o_out.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_in.data.req_type == REQ_PUSH) begin
                    if (r_count < CW'(DEPTH)) n_count = r_count + CW'(1);
                    else n_ovf = 1'b1;
                end else if (acc) begin
                    n_i   = '0;
                    n_pos = i_in.data.descending
                          ? r_count - rank_c + CW'(1)
                          : rank_c;
                    n_out.selected = '0;
                    if (r_ovf) n_out.status = ST_OVERFLOW;
                    else if (r_count == '0) n_out.status = ST_EMPTY;
                    else n_out.status = ST_RANGE;
                end
            end
            S_OUTER_RD: begin
                n_j = '0; n_less = '0; n_equal = '0;
            end
            S_OUTER_WAIT: begin
                n_cand = rdata_a;
                n_jv   = 1'b1;
                n_j    = CW'(1);
            end
            S_INNER: begin
                // rdata_b holds entry j-1 while the valid flag is set
                if (r_j != r_count) begin
                    n_jv = 1'b1;
                    n_j  = r_j + CW'(1);
                end
                if (r_jv || r_j == r_count) begin
                    if (key_b < key_c) n_less = r_less + CW'(1);
                    else if (key_b == key_c) n_equal = r_equal + CW'(1);
                end
                if (!r_jv && r_j == r_count) begin
                    n_less = r_less; n_equal = r_equal;
                end
            end
            S_DONE: begin
                n_i = r_i + CW'(1);
                if ({1'b0, r_less} < {1'b0, r_pos} && {1'b0, r_pos} <= le_sum) begin
                    n_out.selected = r_cand;
                    n_out.status   = ST_OK;
                end else begin
                    n_out.selected = '0;
                    n_out.status   = ST_OK;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_count  = '0;
                n_ovf    = 1'b0;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_jv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            r_jv     <= n_jv;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_j     <= n_j;
        r_less  <= n_less;
        r_equal <= n_equal;
        r_cand  <= n_cand;
        r_out   <= n_out;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_count == '0 && !r_ovf) else $error("set not cleared");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_in.ready) else $error("ready while busy");
`endif
endmodule

@@ src/klss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module klss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ verif/tb_top.sv @@
// Testbench: random and directed push/query traffic for the k-th order statistic selector.
`timescale 1ns / 100ps

module tb_top;
    import klss_pkg::*;

    localparam int Depth    = 64;
    localparam int WdogMax  = 200000;
    localparam int DrainCyc = Depth * (Depth + 2) + 16;

    // Scoreboard: predicts the selected value and status of each query
    class kth_select_sb;
        logic [63:0] set_vals[$];
        bit          set_ovf;
        t_out_item   pending_q[$];
        int          errors;

        function logic [63:0] sort_key(logic [63:0] b);
            sort_key = b[63] ? ~b : (b | 64'h8000_0000_0000_0000);
        endfunction

        // Note an accepted input transfer
        function void note_input(t_in_item it);
            t_out_item r;
            logic [63:0] keys[$];
            int n, k, pos;
            if (it.req_type == REQ_PUSH) begin
                if (set_vals.size() < Depth) set_vals = {set_vals, it.value};
                else set_ovf = 1'b1;
                return;
            end
            n = set_vals.size();
            k = it.rank;
            r.selected = '0;
            if (set_ovf) r.status = ST_OVERFLOW;
            else if (n == 0) r.status = ST_EMPTY;
            else if (k < 1 || k > n) r.status = ST_RANGE;
            else begin
                r.status = ST_OK;
                foreach (set_vals[i]) keys = {keys, sort_key(set_vals[i])};
                keys.sort();
                pos = it.descending ? n - k : k - 1;
                // Invert the key mapping
                r.selected = keys[pos][63] ? (keys[pos] & 64'h7FFF_FFFF_FFFF_FFFF)
                                           : ~keys[pos];
            end
            pending_q = {pending_q, r};
            set_vals.delete();
            set_ovf = 1'b0;
        endfunction

        // Check an accepted result transfer
        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result sel=%h st=%0d", $time, got.selected,
                         got.status);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.selected !== exp.selected) begin
                $display("%0t: selected mismatch exp=%h act=%h", $time, exp.selected,
                         got.selected);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status mismatch exp=%0d act=%0d", $time, exp.status,
                         got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   src_idle = 0;
    int   snk_stall = 0;
    int   wdog = 0;
    int   n_sent = 0;
    kth_select_sb sb;

    klss_in_if  in_ch();
    klss_out_if out_ch();

    kth_largest_smallest_select_top #(.DEPTH(Depth)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Sink side: random stall, check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WdogMax) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one item and hold it until transfer, with random idle gaps first
    task automatic send(t_in_item it);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        n_sent++;
    endtask

    task automatic push(logic [63:0] v);
        t_in_item it;
        it = '0;
        it.req_type = REQ_PUSH;
        it.value = v;
        it.rank = RankW'($urandom);
        it.descending = 1'($urandom);
        send(it);
    endtask

    task automatic query(int k, bit desc);
        t_in_item it;
        it.req_type = REQ_QUERY;
        it.value = {$urandom, $urandom};
        it.rank = RankW'(k);
        it.descending = desc;
        send(it);
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = {1'($urandom_range(1)), 63'h0};
            2: v = {1'($urandom_range(1)), 11'h7FF, 52'h0};
            3: v = {1'($urandom_range(1)), 11'($urandom_range(1020, 1026)), 49'h0,
                    3'($urandom)};
            default: v = {1'($urandom_range(1)), 11'($urandom), 52'($urandom_range(3))};
        endcase
        return v;
    endfunction

    // Random set of n pushes (at times more than Depth) then one query, at times out of range
    task automatic rand_set();
        int n, k;
        n = ($urandom_range(19) == 0) ? $urandom_range(Depth + 3) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push(rand_double());
        case ($urandom_range(9))
            0: k = $signed(16'($urandom));
            1: k = $urandom_range(1) ? 0 : n + 1;
            default: k = $urandom_range(1, (n > 0) ? n : 1);
        endcase
        query(k, 1'($urandom));
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty set, extremes, duplicates, signed zeros, overflow
        query(1, 1'b0);
        push(64'h8000_0000_0000_0000); push(64'h0); push(64'hFFFF_FFFF_FFFF_FFFF);
        push(64'h7FF0_0000_0000_0000); push(64'h0);
        query(1, 1'b0);
        push(64'h3FF0_0000_0000_0000); push(64'hBFF0_0000_0000_0000);
        query(1, 1'b1);
        push(64'h1); query(-32768, 1'b0);
        push(64'h1); query(32767, 1'b1);
        push(64'h1); query(0, 1'b0);
        push(64'h1); push(64'h2); query(2, 1'b0);
        for (int i = 0; i < Depth + 1; i++) push(rand_double());
        query(1, 1'b0);
        for (int i = 0; i < Depth; i++) push(rand_double());
        query(Depth, 1'b1);

        // Random phases with varied idling and stalls; a drain pause after each phase
        for (int ph = 0; ph < 4; ph++) begin
            src_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 34 : 64) : 0;
            snk_stall = (ph == 2) ? 64 : ((ph == 3) ? 34 : 0);
            while (n_sent < (ph + 1) * 500) begin
                rand_set();
            end
            in_ch.valid <= 1'b0;
            while (sb.pending_q.size() != 0) @(posedge i_clk);
        end

        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DrainCyc) @(posedge i_clk);
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
